// ===== rtl/core/wamm_pkg.sv =====
// Shared constants and control types for the windowed average, minimum and maximum unit.
package wamm_pkg;

  localparam int WINDOW   = 20;
  localparam int SAMPLE_W = 32;
  localparam int CNT_W    = $clog2(WINDOW + 1);
  localparam int POS_W    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int SUM_W    = SAMPLE_W + CNT_W;
  localparam int STEP_W   = $clog2(SUM_W);

  typedef struct packed {
    logic accept;
    logic update;
    logic div_step;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic out_free;
  } status_t;

endpackage

// ===== rtl/core/windowed_average_min_max_unit.sv =====
// Top level of the windowed average, minimum and maximum unit.
// Each sample goes through accept, update, divider steps of one quotient bit each,
// and load; no new sample is accepted until its result is loaded, and a result
// still waiting holds off the next load.
// Reset: synchronous; clears ring position, fill count, sum and extremes;
// ring contents stay undefined and need no clearing pass.
module windowed_average_min_max_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [wamm_pkg::SAMPLE_W-1:0]   s_tdata,   // sample_ms
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [3*wamm_pkg::SAMPLE_W-1:0] m_tdata    // average_ms, minimum_ms, maximum_ms
);
  import wamm_pkg::*;

  cmd_t    cmd;
  status_t status;

  wamm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  wamm_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .status   (status),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

// ===== rtl/core/wamm_ctrl.sv =====
// Controller state machine sequencing transfer, update, division and result load.
module wamm_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  wamm_pkg::status_t status,
  output wamm_pkg::cmd_t    cmd
);
  import wamm_pkg::*;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_UPDATE = 2'd1;
  localparam logic [1:0] ST_DIV    = 2'd2;
  localparam logic [1:0] ST_FINISH = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    cmd          = '0;
    s_tready     = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.accept = 1'b1;
          state_next = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        cmd.update = 1'b1;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_done) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/core/wamm_dp.sv =====
// Datapath: sample ring, running sum, extremes, restoring divider and output register.
module wamm_dp (
  input  logic                            clk,
  input  logic                            rst,
  input  wamm_pkg::cmd_t                  cmd,
  output wamm_pkg::status_t               status,
  input  logic [wamm_pkg::SAMPLE_W-1:0]   s_tdata,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [3*wamm_pkg::SAMPLE_W-1:0] m_tdata
);
  import wamm_pkg::*;

  logic [SAMPLE_W-1:0] ring [WINDOW];
  logic [SAMPLE_W-1:0] sample_q;
  logic [SAMPLE_W-1:0] old_q;
  logic [POS_W-1:0]    pos;
  logic [CNT_W-1:0]    fill;
  logic [SUM_W-1:0]    sum;
  logic [SUM_W-1:0]    sum_next;
  logic [SAMPLE_W-1:0] lo;
  logic [SAMPLE_W-1:0] hi;
  logic [SUM_W-1:0]    qr;
  logic [CNT_W-1:0]    rem;
  logic [CNT_W:0]      trial;
  logic                ge;
  logic [STEP_W-1:0]   step;
  logic                full;
  logic                first;

  assign full  = (fill == CNT_W'(WINDOW));
  assign first = (fill == '0);

  always_comb begin
    sum_next = sum + SUM_W'(sample_q);
    if (full) begin
      sum_next = sum_next - SUM_W'(old_q);
    end
  end

  assign trial = {rem, qr[SUM_W-1]};
  assign ge    = (trial >= {1'b0, fill});

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      sample_q <= s_tdata;
      old_q    <= ring[pos];
    end
    if (cmd.update) begin
      ring[pos] <= sample_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos  <= '0;
      fill <= '0;
      sum  <= '0;
      lo   <= '0;
      hi   <= '0;
      step <= '0;
    end else if (cmd.update) begin
      pos  <= (pos == POS_W'(WINDOW - 1)) ? '0 : pos + POS_W'(1);
      if (!full) begin
        fill <= fill + CNT_W'(1);
      end
      sum  <= sum_next;
      if (first || sample_q < lo) begin
        lo <= sample_q;
      end
      if (first || sample_q > hi) begin
        hi <= sample_q;
      end
      step <= '0;
    end else if (cmd.div_step) begin
      step <= step + STEP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      qr  <= sum_next;
      rem <= '0;
    end else if (cmd.div_step) begin
      qr  <= {qr[SUM_W-2:0], ge};
      rem <= ge ? trial[CNT_W-1:0] - fill : trial[CNT_W-1:0];
    end
  end

  assign status.div_done = (step == STEP_W'(SUM_W - 1));
  assign status.out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      m_tdata <= {hi, lo, qr[SAMPLE_W-1:0]};
    end
  end

endmodule
